// ===== hw/rtl/glo_pkg.sv =====
// Types and constants shared by the grid line orientation angle block.
// Holds the transaction structs, state encodings and the CORDIC arctangent table.
// No dependencies.
package glo_pkg;

    typedef struct packed {
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic               last_of_line;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] angle;
        logic               line_end;
        logic               run_last;
        logic               too_short;
    } out_item_t;

    // Handshake from the CORDIC unit back to the sequencer.
    typedef struct packed {
        logic               done;
        logic signed [15:0] angle;
    } cordic_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN1,
        ST_EMIT1,
        ST_RUN2,
        ST_EMIT2
    } glo_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_NORM,
        C_ROT,
        C_FIN
    } cordic_state_t;

    // Nodes of the current line held in the neighbour registers.
    localparam logic [1:0] NODES_NONE = 2'd0;
    localparam logic [1:0] NODES_ONE  = 2'd1;
    localparam logic [1:0] NODES_TWO  = 2'd2;

    localparam int NORM_W   = 60;  // magnitude is normalised so that bit 59 is set
    localparam int DATA_W   = 64;  // CORDIC x and y
    localparam int Z_W      = 35;  // angle accumulator, Q29 radians
    localparam int ATAN_LEN = 24;

    localparam logic signed [Z_W-1:0] PI_Q29      = 35'sd1686629713;
    localparam logic signed [Z_W-1:0] ROUND_HALF  = 35'sd32768;
    localparam logic signed [Z_W-1:0] ANGLE_MAX_Z = 35'sd25736;
    localparam logic signed [15:0]    ANGLE_MAX   = 16'sd25736;

    // atan(2^-i) in Q29, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_q29(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:    v = 35'sd421657428;
            5'd1:    v = 35'sd248918915;
            5'd2:    v = 35'sd131521918;
            5'd3:    v = 35'sd66762579;
            5'd4:    v = 35'sd33510843;
            5'd5:    v = 35'sd16771758;
            5'd6:    v = 35'sd8387925;
            5'd7:    v = 35'sd4194219;
            5'd8:    v = 35'sd2097141;
            5'd9:    v = 35'sd1048575;
            5'd10:   v = 35'sd524288;
            5'd11:   v = 35'sd262144;
            5'd12:   v = 35'sd131072;
            5'd13:   v = 35'sd65536;
            5'd14:   v = 35'sd32768;
            5'd15:   v = 35'sd16384;
            5'd16:   v = 35'sd8192;
            5'd17:   v = 35'sd4096;
            5'd18:   v = 35'sd2048;
            5'd19:   v = 35'sd1024;
            5'd20:   v = 35'sd512;
            5'd21:   v = 35'sd256;
            5'd22:   v = 35'sd128;
            5'd23:   v = 35'sd64;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/grid_line_orientation_angle.sv =====
// Top level of the grid line orientation angle block: node sequencer, neighbour
// registers, result register and one shared CORDIC unit.
// Depends on glo_pkg and glo_cordic.
//
//  Channel | Direction | Handshake         | Payload
//  --------+-----------+-------------------+-------------------------------------------
//  s_      | in        | s_valid / s_ready | glo_pkg::in_item_t  (x_coord, y_coord, last)
//  m_      | out       | m_valid / m_ready | glo_pkg::out_item_t (angle, flags)
//
// A nonzero difference keeps the CORDIC unit busy through normalising, rotation and a
// final state; the spread in its run time comes from the normalising shifter, and a
// zero difference goes straight to the final state.
// A node with no result is only taken in, a one-node line emits one zero-angle result,
// other nodes emit one angle, and a line's last node also emits the line-end result.
// s_ready is high only while the sequencer is idle; a finished result waits in the
// output register without holding up the next transaction.
// Reset (aresetn low at a clock edge) empties the output register and starts a new line.
module grid_line_orientation_angle #(
    parameter int COORD_WIDTH  = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  glo_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output glo_pkg::out_item_t  m_item
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 1;

    glo_pkg::glo_state_t   state_reg, state_next;
    logic [1:0]            nodes_reg;

    logic signed [CW-1:0]  older_x_reg, older_y_reg, recent_x_reg, recent_y_reg;
    logic signed [DW-1:0]  dx_b_reg, dy_b_reg;
    logic                  last_reg, need_b_reg, short_reg;
    logic signed [15:0]    ang_reg;

    logic                  m_valid_reg;
    glo_pkg::out_item_t    m_item_reg;

    logic signed [CW-1:0]  x_in, y_in;
    logic signed [DW-1:0]  x_ext, y_ext;
    logic signed [DW-1:0]  dx_a, dy_a, dx_b, dy_b;
    logic signed [DW-1:0]  cdx, cdy;
    logic                  accept, out_free, load_out, cordic_start;
    glo_pkg::out_item_t    out_next;
    glo_pkg::cordic_rsp_t  crsp;

    if (COORD_WIDTH <= 32) begin : g_narrow
        assign x_in = s_item.x_coord[COORD_WIDTH-1:0];
        assign y_in = s_item.y_coord[COORD_WIDTH-1:0];
    end else begin : g_wide
        assign x_in = {{(COORD_WIDTH-32){1'b0}}, s_item.x_coord};
        assign y_in = {{(COORD_WIDTH-32){1'b0}}, s_item.y_coord};
    end

    assign x_ext = {x_in[CW-1], x_in};
    assign y_ext = {y_in[CW-1], y_in};

    // Central difference once two neighbours are held, forward difference otherwise.
    assign dx_a = (nodes_reg == glo_pkg::NODES_ONE)
                ? x_ext - {recent_x_reg[CW-1], recent_x_reg}
                : x_ext - {older_x_reg[CW-1], older_x_reg};
    assign dy_a = (nodes_reg == glo_pkg::NODES_ONE)
                ? y_ext - {recent_y_reg[CW-1], recent_y_reg}
                : y_ext - {older_y_reg[CW-1], older_y_reg};
    assign dx_b = x_ext - {recent_x_reg[CW-1], recent_x_reg};
    assign dy_b = y_ext - {recent_y_reg[CW-1], recent_y_reg};

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            glo_pkg::ST_IDLE: begin
                if (accept) begin
                    if (nodes_reg != glo_pkg::NODES_NONE) begin
                        state_next = glo_pkg::ST_RUN1;
                    end else if (s_item.last_of_line) begin
                        state_next = glo_pkg::ST_EMIT2;
                    end
                end
            end
            glo_pkg::ST_RUN1: begin
                if (crsp.done) begin
                    state_next = glo_pkg::ST_EMIT1;
                end
            end
            glo_pkg::ST_EMIT1: begin
                if (out_free) begin
                    priority if (!last_reg) begin
                        state_next = glo_pkg::ST_IDLE;
                    end else if (need_b_reg) begin
                        state_next = glo_pkg::ST_RUN2;
                    end else begin
                        state_next = glo_pkg::ST_EMIT2;
                    end
                end
            end
            glo_pkg::ST_RUN2: begin
                if (crsp.done) begin
                    state_next = glo_pkg::ST_EMIT2;
                end
            end
            glo_pkg::ST_EMIT2: begin
                if (out_free) begin
                    state_next = glo_pkg::ST_IDLE;
                end
            end
            default: state_next = glo_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready      = 1'b0;
        cordic_start = 1'b0;
        load_out     = 1'b0;
        cdx          = dx_a;
        cdy          = dy_a;
        out_next     = '{angle: ang_reg, line_end: 1'b0, run_last: 1'b0, too_short: 1'b0};
        unique case (state_reg)
            glo_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cordic_start = accept && (nodes_reg != glo_pkg::NODES_NONE);
            end
            glo_pkg::ST_EMIT1: begin
                load_out          = out_free;
                cordic_start      = out_free && last_reg && need_b_reg;
                cdx               = dx_b_reg;
                cdy               = dy_b_reg;
                out_next.run_last = !last_reg;
            end
            glo_pkg::ST_EMIT2: begin
                load_out           = out_free;
                out_next.line_end  = 1'b1;
                out_next.run_last  = 1'b1;
                out_next.too_short = short_reg;
            end
            glo_pkg::ST_RUN1, glo_pkg::ST_RUN2: begin
            end
            default: begin
            end
        endcase
    end

    glo_cordic #(
        .COORD_WIDTH  (COORD_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .dx      (cdx),
        .dy      (cdy),
        .rsp     (crsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= glo_pkg::ST_IDLE;
            nodes_reg   <= glo_pkg::NODES_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                if (s_item.last_of_line) begin
                    nodes_reg <= glo_pkg::NODES_NONE;
                end else if (nodes_reg == glo_pkg::NODES_NONE) begin
                    nodes_reg <= glo_pkg::NODES_ONE;
                end else begin
                    nodes_reg <= glo_pkg::NODES_TWO;
                end
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg   <= s_item.last_of_line;
            short_reg  <= (nodes_reg == glo_pkg::NODES_NONE);
            need_b_reg <= (nodes_reg == glo_pkg::NODES_TWO);
            dx_b_reg   <= dx_b;
            dy_b_reg   <= dy_b;
            if (nodes_reg == glo_pkg::NODES_NONE) begin
                // A lone node has angle zero; otherwise it becomes the first neighbour.
                ang_reg <= '0;
                if (!s_item.last_of_line) begin
                    recent_x_reg <= x_in;
                    recent_y_reg <= y_in;
                end
            end else if (!s_item.last_of_line) begin
                older_x_reg  <= recent_x_reg;
                older_y_reg  <= recent_y_reg;
                recent_x_reg <= x_in;
                recent_y_reg <= y_in;
            end
        end else if (crsp.done) begin
            ang_reg <= crsp.angle;
        end
        if (load_out) begin
            m_item_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== hw/rtl/glo_cordic.sv =====
// Iterative vectoring CORDIC that turns a difference vector (dx, dy) into a Q3.13 angle.
// A normalising shifter brings the larger magnitude up to bit 59, then one shared
// rotation stage runs once per cycle. Depends on glo_pkg.
module glo_cordic #(
    parameter int COORD_WIDTH  = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [COORD_WIDTH:0] dx,
    input  logic signed [COORD_WIDTH:0] dy,
    output glo_pkg::cordic_rsp_t      rsp
);

    localparam int DW    = COORD_WIDTH + 1;
    localparam int STEPS = (CORDIC_STEPS < glo_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                               : glo_pkg::ATAN_LEN;
    localparam int IW    = $clog2(STEPS);

    glo_pkg::cordic_state_t state_reg, state_next;

    logic [glo_pkg::NORM_W-1:0]       ax_reg, ay_reg, mx_reg;
    logic                             y_neg_reg;
    logic signed [glo_pkg::DATA_W-1:0] x_reg, y_reg;
    logic signed [glo_pkg::Z_W-1:0]   z_reg;
    logic [IW-1:0]                    i_reg;

    // Start values
    logic [DW-1:0]                    ax_in, ay_in, mx_in;
    logic                             dx_neg, dy_neg, vec_zero;
    logic signed [glo_pkg::Z_W-1:0]   z_in;
    logic                             y_neg_in;

    // Normalising shifter
    logic [glo_pkg::NORM_W-1:0]       ax_sh, ay_sh, mx_sh;

    // Rotation stage
    logic signed [glo_pkg::DATA_W-1:0] x_load, y_mag, xs, ys;
    logic signed [glo_pkg::Z_W-1:0]   atan_val;
    logic signed [glo_pkg::Z_W-1:0]   z_round, z_shift;

    assign dx_neg   = dx[DW-1];
    assign dy_neg   = dy[DW-1];
    assign vec_zero = (dx == '0) && (dy == '0);
    assign ax_in    = dx_neg ? DW'(-dx) : DW'(dx);
    assign ay_in    = dy_neg ? DW'(-dy) : DW'(dy);
    assign mx_in    = (ax_in > ay_in) ? ax_in : ay_in;

    // Vectors in the left half plane are reflected by pi before rotating.
    assign z_in     = dx_neg ? (dy_neg ? -glo_pkg::PI_Q29 : glo_pkg::PI_Q29) : '0;
    assign y_neg_in = dx_neg ? (!dy_neg && (dy != '0)) : dy_neg;

    always_comb begin
        priority if (mx_reg[glo_pkg::NORM_W-1 -: 16] == '0) begin
            ax_sh = ax_reg << 16;
            ay_sh = ay_reg << 16;
            mx_sh = mx_reg << 16;
        end else if (mx_reg[glo_pkg::NORM_W-1 -: 4] == '0) begin
            ax_sh = ax_reg << 4;
            ay_sh = ay_reg << 4;
            mx_sh = mx_reg << 4;
        end else begin
            ax_sh = ax_reg << 1;
            ay_sh = ay_reg << 1;
            mx_sh = mx_reg << 1;
        end
    end

    assign x_load   = signed'({{(glo_pkg::DATA_W - glo_pkg::NORM_W){1'b0}}, ax_reg});
    assign y_mag    = signed'({{(glo_pkg::DATA_W - glo_pkg::NORM_W){1'b0}}, ay_reg});
    assign xs       = x_reg >>> i_reg;
    assign ys       = y_reg >>> i_reg;
    assign atan_val = glo_pkg::atan_q29(5'(i_reg));
    assign z_round  = z_reg + glo_pkg::ROUND_HALF;
    assign z_shift  = z_round >>> 16;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            glo_pkg::C_IDLE: begin
                if (start) begin
                    state_next = vec_zero ? glo_pkg::C_FIN : glo_pkg::C_NORM;
                end
            end
            glo_pkg::C_NORM: begin
                if (mx_reg[glo_pkg::NORM_W-1]) begin
                    state_next = glo_pkg::C_ROT;
                end
            end
            glo_pkg::C_ROT: begin
                if (i_reg == IW'(STEPS - 1)) begin
                    state_next = glo_pkg::C_FIN;
                end
            end
            glo_pkg::C_FIN: begin
                state_next = glo_pkg::C_IDLE;
            end
            default: state_next = glo_pkg::C_IDLE;
        endcase
    end

    // Outputs: final rounding and saturation of the accumulated angle
    always_comb begin
        rsp.done  = (state_reg == glo_pkg::C_FIN);
        if (z_shift > glo_pkg::ANGLE_MAX_Z) begin
            rsp.angle = glo_pkg::ANGLE_MAX;
        end else if (z_shift < -glo_pkg::ANGLE_MAX_Z) begin
            rsp.angle = -glo_pkg::ANGLE_MAX;
        end else begin
            rsp.angle = z_shift[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= glo_pkg::C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            glo_pkg::C_IDLE: begin
                if (start) begin
                    ax_reg    <= glo_pkg::NORM_W'(ax_in);
                    ay_reg    <= glo_pkg::NORM_W'(ay_in);
                    mx_reg    <= glo_pkg::NORM_W'(mx_in);
                    z_reg     <= z_in;
                    y_neg_reg <= y_neg_in;
                end
            end
            glo_pkg::C_NORM: begin
                if (mx_reg[glo_pkg::NORM_W-1]) begin
                    x_reg <= x_load;
                    y_reg <= y_neg_reg ? -y_mag : y_mag;
                    i_reg <= '0;
                end else begin
                    ax_reg <= ax_sh;
                    ay_reg <= ay_sh;
                    mx_reg <= mx_sh;
                end
            end
            glo_pkg::C_ROT: begin
                if (!y_reg[glo_pkg::DATA_W-1]) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_val;
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_val;
                end
                i_reg <= i_reg + 1'b1;
            end
            glo_pkg::C_FIN: begin
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/glo_checker.sv =====
// Port-level checks for the grid line orientation angle block, attached by bind.
// Depends on glo_pkg and grid_line_orientation_angle.
module glo_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input glo_pkg::out_item_t m_item
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // The one-node case always closes the line with a zero angle.
    a_short_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.too_short |->
            (m_item.angle == 16'sd0) && m_item.line_end && m_item.run_last)
        else $error("one-node result malformed");

    // The angle of a line's last node is always the final result of its transaction.
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.line_end |-> m_item.run_last)
        else $error("line end without run_last");

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.angle <= glo_pkg::ANGLE_MAX) &&
                    (m_item.angle >= -glo_pkg::ANGLE_MAX))
        else $error("angle outside plus or minus pi");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind grid_line_orientation_angle glo_checker u_glo_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
